>>> rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit engine package
// Command codes, start status codes and the result word shared by the
// sequencer, the output stage and the top level.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

   typedef enum logic [2:0] {
      MODE_NONE    = 3'd0,
      MODE_START   = 3'd1,
      MODE_STOP    = 3'd2,
      MODE_SEND    = 3'd3,
      MODE_RECV    = 3'd4,
      MODE_ACK     = 3'd5,
      MODE_NACK    = 3'd6,
      MODE_WAITACK = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      START_OK   = 2'd0,
      START_BUSY = 2'd1,
      START_ERR  = 2'd2
   } start_status_type;

   typedef struct packed {
      logic             scl_level;
      logic             sda_level;
      logic             busy_res;
      logic             done_res;
      logic [7:0]       rx_byte;
      logic             ack_seen;
      start_status_type start_status;
   } rsp_word_type;

endpackage

>>> rtl/i2cbm_seq.sv
// ----------------------------------------------------------------------------
// I2C bit engine sequencer
// Holds the bus state and the phase length register; computes the next
// state and the result word for one tick.
// ----------------------------------------------------------------------------
module i2cbm_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tick,
   input  logic [2:0]              mode,
   input  logic [7:0]              tx_byte,
   input  logic                    sda_in,
   input  logic                    csr_write,
   input  logic [15:0]             csr_data,
   output i2cbm_pkg::rsp_word_type word
);

   i2cbm_pkg::mode_type         cmd_ff, cmd_in;
   logic [1:0]                  step_ff, step_in;
   logic [15:0]                 pc_ff, pc_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [3:0]                  bc_ff, bc_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in_nx;
   logic [7:0]                  rx_ff, rx_in;
   logic                        ack_ff, ack_in;
   i2cbm_pkg::start_status_type st_ff, st_in;
   logic [15:0]                 ticks_ff, ticks_in;
   logic                        done;

   // drive change at the start of a phase, returns {scl, sda}
   function automatic logic [1:0] apply_phase(i2cbm_pkg::mode_type cmd, logic [1:0] stp,
                                              logic msb, logic scl, logic sda);
      logic s, d;
      s = scl;
      d = sda;
      unique case (cmd) inside
         i2cbm_pkg::MODE_START: begin
            if (stp == 2'd0) begin
               s = 1'b1;
               d = 1'b1;
            end else d = 1'b0;
         end
         i2cbm_pkg::MODE_STOP: begin
            if (stp == 2'd0) s = 1'b0;
            else if (stp == 2'd1) d = 1'b0;
            else if (stp == 2'd2) s = 1'b1;
            else d = 1'b1;
         end
         i2cbm_pkg::MODE_SEND: begin
            if (stp == 2'd0) s = 1'b0;
            else if (stp == 2'd1) d = msb;
            else s = 1'b1;
         end
         i2cbm_pkg::MODE_RECV: s = (stp != 2'd0);
         i2cbm_pkg::MODE_ACK, i2cbm_pkg::MODE_NACK: begin
            if (stp == 2'd0) s = 1'b0;
            else if (stp == 2'd1) d = (cmd == i2cbm_pkg::MODE_NACK);
            else if (stp == 2'd2) s = 1'b1;
            else s = 1'b0;
         end
         i2cbm_pkg::MODE_WAITACK: begin
            if (stp == 2'd0) s = 1'b0;
            else if (stp == 2'd1) d = 1'b1;
            else s = 1'b1;
         end
         default: ;
      endcase
      return {s, d};
   endfunction

   always_comb begin
      logic [15:0] ticks;
      logic [3:0]  bc_inc;
      logic        fin;
      logic        adv;
      i2cbm_pkg::mode_type m;
      cmd_in    = cmd_ff;
      step_in   = step_ff;
      pc_in     = pc_ff;
      shift_in  = shift_ff;
      bc_in     = bc_ff;
      scl_in    = scl_ff;
      sda_in_nx = sda_ff;
      rx_in     = rx_ff;
      ack_in    = ack_ff;
      st_in     = st_ff;
      done      = 1'b0;
      fin       = 1'b0;
      adv       = 1'b0;
      m         = i2cbm_pkg::mode_type'(mode);
      ticks     = (ticks_ff == 16'd0) ? 16'd1 : ticks_ff;
      bc_inc    = bc_ff + 4'd1;
      if (cmd_ff == i2cbm_pkg::MODE_NONE) begin
         if (m != i2cbm_pkg::MODE_NONE) begin
            cmd_in   = m;
            step_in  = 2'd0;
            bc_in    = 4'd0;
            shift_in = (m == i2cbm_pkg::MODE_SEND) ? tx_byte : 8'd0;
            if (m == i2cbm_pkg::MODE_RECV) sda_in_nx = 1'b1;
            {scl_in, sda_in_nx} = apply_phase(m, 2'd0, shift_in[7], scl_in, sda_in_nx);
            pc_in    = 16'd1;
         end
      end else if (pc_ff < ticks) begin
         pc_in = pc_ff + 16'd1;
      end else begin
         unique case (cmd_ff) inside
            i2cbm_pkg::MODE_START: begin
               if (step_ff == 2'd0 && !sda_in) begin
                  st_in = i2cbm_pkg::START_BUSY;
                  fin   = 1'b1;
               end else if (step_ff == 2'd1 && sda_in) begin
                  st_in = i2cbm_pkg::START_ERR;
                  fin   = 1'b1;
               end else if (step_ff == 2'd2) begin
                  st_in = i2cbm_pkg::START_OK;
                  fin   = 1'b1;
               end else adv = 1'b1;
            end
            i2cbm_pkg::MODE_STOP, i2cbm_pkg::MODE_ACK, i2cbm_pkg::MODE_NACK: begin
               if (step_ff == 2'd3) fin = 1'b1;
               else adv = 1'b1;
            end
            i2cbm_pkg::MODE_SEND: begin
               if (step_ff == 2'd1) shift_in = {shift_ff[6:0], 1'b0};
               if (step_ff >= 2'd2) begin
                  bc_in = bc_inc;
                  if (bc_inc[3]) begin
                     scl_in = 1'b0;
                     fin    = 1'b1;
                  end else begin
                     step_in = 2'd0;
                     scl_in  = 1'b0;
                  end
               end else adv = 1'b1;
            end
            i2cbm_pkg::MODE_RECV: begin
               if (step_ff >= 2'd1) begin
                  shift_in = {shift_ff[6:0], sda_in};
                  bc_in    = bc_inc;
                  if (bc_inc[3]) begin
                     scl_in = 1'b0;
                     rx_in  = shift_in;
                     fin    = 1'b1;
                  end else begin
                     step_in = 2'd0;
                     scl_in  = 1'b0;
                  end
               end else adv = 1'b1;
            end
            i2cbm_pkg::MODE_WAITACK: begin
               if (step_ff >= 2'd2) begin
                  ack_in = !sda_in;
                  scl_in = 1'b0;
                  fin    = 1'b1;
               end else adv = 1'b1;
            end
            default: fin = 1'b1;
         endcase
         if (adv) begin
            step_in = step_ff + 2'd1;
            {scl_in, sda_in_nx} = apply_phase(cmd_ff, step_in, shift_in[7], scl_in, sda_in_nx);
         end
         if (fin) begin
            cmd_in  = i2cbm_pkg::MODE_NONE;
            step_in = 2'd0;
            pc_in   = 16'd0;
            done    = 1'b1;
         end else pc_in = 16'd1;
      end
   end

   assign ticks_in = csr_write ? csr_data : ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= i2cbm_pkg::MODE_NONE;
         step_ff  <= 2'd0;
         pc_ff    <= 16'd0;
         shift_ff <= 8'd0;
         bc_ff    <= 4'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         rx_ff    <= 8'd0;
         ack_ff   <= 1'b0;
         st_ff    <= i2cbm_pkg::START_OK;
         ticks_ff <= i2cbm_pkg::PHASE_TICKS_RESET;
      end else begin
         ticks_ff <= ticks_in;
         if (tick) begin
            cmd_ff   <= cmd_in;
            step_ff  <= step_in;
            pc_ff    <= pc_in;
            shift_ff <= shift_in;
            bc_ff    <= bc_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in_nx;
            rx_ff    <= rx_in;
            ack_ff   <= ack_in;
            st_ff    <= st_in;
         end
      end
   end

   always_comb begin
      word.scl_level    = scl_in;
      word.sda_level    = sda_in_nx;
      word.busy_res     = (cmd_in != i2cbm_pkg::MODE_NONE);
      word.done_res     = done;
      word.rx_byte      = rx_in;
      word.ack_seen     = ack_in;
      word.start_status = st_in;
   end

endmodule

>>> rtl/i2cbm_out.sv
// ----------------------------------------------------------------------------
// I2C bit engine result register
// Holds one result word and its valid flag; stalls the input side only
// while a held word is not taken.
// ----------------------------------------------------------------------------
module i2cbm_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  i2cbm_pkg::rsp_word_type word_in,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    hold,
   output i2cbm_pkg::rsp_word_type word_out
);

   logic                    valid_ff, valid_in;
   i2cbm_pkg::rsp_word_type word_ff;

   assign hold     = valid_ff && rsp_stall;
   assign valid_in = load || hold;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign word_out  = word_ff;

endmodule

>>> rtl/i2c_bit_level_master_unit.sv
// ----------------------------------------------------------------------------
// I2C bit level master
// Open-drain I2C master, one request word per bus tick.
//
// req_*: one word per tick (mode, tx_byte, sampled sda_in). A word is taken
//    on an edge with req_valid high and req_stall low.
// rsp_*: one result word per request word: SCL/SDA drive levels, busy,
//    done, last received byte, last ack and last start status.
// csr_*: phase length in ticks, written when csr_valid is high; csr_ready
//    is always high. A phase length of zero acts as one.
// Result: the result of a word is registered and valid on rsp_* in the
//    cycle after it is taken. Throughput: one word per cycle while req_stall
//    is low, set by the single state update of the bus sequencer.
// Stall: a held result stays on rsp_* while rsp_stall is high; req_stall is
//    raised only then, so one word per cycle flows when the output drains.
// Reset: drives released, no command running, phase length 10, status
//    fields zero, result register empty.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_seen,
   output logic [1:0]  rsp_start_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_phase_ticks
);

   i2cbm_pkg::rsp_word_type next_word, out_word;
   logic                    tick;
   logic                    hold;

   assign csr_ready = 1'b1;
   assign req_stall = hold;
   assign tick      = req_valid && !hold;

   i2cbm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .mode      (req_mode),
      .tx_byte   (req_tx_byte),
      .sda_in    (req_sda_in),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_phase_ticks),
      .word      (next_word)
   );

   i2cbm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (tick),
      .word_in   (next_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .hold      (hold),
      .word_out  (out_word)
   );

   assign rsp_scl_level    = out_word.scl_level;
   assign rsp_sda_level    = out_word.sda_level;
   assign rsp_busy_res     = out_word.busy_res;
   assign rsp_done_res     = out_word.done_res;
   assign rsp_rx_byte      = out_word.rx_byte;
   assign rsp_ack_seen     = out_word.ack_seen;
   assign rsp_start_status = out_word.start_status;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_start_status <= i2cbm_pkg::START_ERR)
      else $error("start status out of range");

endmodule
